/* src/pntu_pkg.sv */
// ----------------------------------------------------------------------------
// pntu_pkg
// Shared types, constants and functions for the peer node table.
// ----------------------------------------------------------------------------
package pntu_pkg;

  localparam logic [1:0] ACT_ALIVE  = 2'd0;
  localparam logic [1:0] ACT_FULL   = 2'd1;
  localparam logic [1:0] ACT_SELF   = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  localparam logic [1:0] REG_INTERVAL = 2'd0;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic scan_start;
    logic [1:0] scan_mode;
    logic apply;
    logic result;
  } pntu_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic have_free;
    logic have_victim;
  } pntu_sts_t;

  localparam logic [1:0] SCAN_FIND  = 2'd0;
  localparam logic [1:0] SCAN_GREY  = 2'd1;
  localparam logic [1:0] SCAN_ANY   = 2'd2;
  localparam logic [1:0] SCAN_COLL  = 2'd3;

  // Processes one byte of the CRC, eight dependent narrow steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic seq_newer(input logic [15:0] inc, input logic [15:0] last);
    logic [15:0] d;
    d = inc - last;
    return (d != 16'd0) && !d[15];
  endfunction

endpackage

/* src/pntu_ctrl.sv */
// ----------------------------------------------------------------------------
// pntu_ctrl
// Sequencer for the table: lookup scan, eviction scans, update, collision scan.
// ----------------------------------------------------------------------------
module pntu_ctrl import pntu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] action,
  input  pntu_sts_t sts,
  output pntu_cmd_t cmd,
  output logic      busy,
  output logic      fail
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FIND  = 7'b0000010,
    ST_GREY  = 7'b0000100,
    ST_ANY   = 7'b0001000,
    ST_APPLY = 7'b0010000,
    ST_COLL  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [1:0] act;
  logic fail_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      act   <= ACT_ALIVE;
      fail  <= 1'b0;
    end else begin
      state <= state_next;
      fail  <= fail_next;
      if (start && !busy) begin
        act <= action;
      end
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    fail_next  = fail;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next     = ST_FIND;
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_FIND;
          fail_next      = 1'b0;
        end
      end
      ST_FIND: begin
        if (sts.scan_done) begin
          if (sts.found || sts.have_free) begin
            if (!sts.found && act == ACT_LOOKUP) begin
              fail_next  = 1'b1;
              state_next = ST_DONE;
            end else begin
              state_next = ST_APPLY;
            end
          end else if (act == ACT_LOOKUP) begin
            fail_next  = 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next     = ST_GREY;
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_GREY;
          end
        end
      end
      ST_GREY: begin
        if (sts.scan_done) begin
          if (sts.have_victim) begin
            state_next = ST_APPLY;
          end else if (act == ACT_SELF) begin
            state_next     = ST_ANY;
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_ANY;
          end else begin
            fail_next  = 1'b1;
            state_next = ST_DONE;
          end
        end
      end
      ST_ANY: begin
        if (sts.scan_done) begin
          if (sts.have_victim) begin
            state_next = ST_APPLY;
          end else begin
            fail_next  = 1'b1;
            state_next = ST_DONE;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply      = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = SCAN_COLL;
        state_next     = ST_COLL;
      end
      ST_COLL: begin
        if (sts.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.result = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/pntu_dp.sv */
// ----------------------------------------------------------------------------
// pntu_dp
// Table storage, one-slot-per-cycle scan unit, update logic and result word.
// ----------------------------------------------------------------------------
module pntu_dp import pntu_pkg::*; #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [1:0]  action,
  input  logic [47:0] node_id,
  input  logic [15:0] seq,
  input  logic        fix_valid,
  input  logic signed [30:0] lat,
  input  logic signed [31:0] lon,
  input  logic signed [7:0] rssi,
  input  logic [31:0] now_ms,
  input  logic [15:0] interval,
  input  pntu_cmd_t   cmd,
  input  logic        fail,
  output pntu_sts_t   sts,
  output logic        done,
  output logic        ok,
  output logic [4:0]  slot,
  output logic [15:0] node_sid,
  output logic        collision,
  output logic        grey,
  output logic        is_self,
  output logic        has_position,
  output logic signed [30:0] out_lat,
  output logic signed [31:0] out_lon,
  output logic [15:0] stored_seq,
  output logic signed [7:0] stored_rssi,
  output logic [15:0] age_s
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] used, self_bit;
  logic [47:0] key_q [TABLE_ENTRIES];
  logic [15:0] sid_q [TABLE_ENTRIES];
  logic [31:0] seen_q [TABLE_ENTRIES];
  logic [15:0] seq_q [TABLE_ENTRIES];
  logic [7:0]  rssi_q [TABLE_ENTRIES];
  logic        pv_q [TABLE_ENTRIES];
  logic [30:0] lat_q [TABLE_ENTRIES];
  logic [31:0] lon_q [TABLE_ENTRIES];

  logic [1:0]  act;
  logic [47:0] in_key;
  logic [15:0] in_seq;
  logic        in_pv;
  logic [30:0] in_lat;
  logic [31:0] in_lon;
  logic [7:0]  in_rssi;
  logic [31:0] now;
  logic [15:0] sid_new;
  logic [1:0]  crc_cnt;

  logic        scanning;
  logic        scan_done;
  logic [1:0]  mode;
  logic [IW-1:0] idx;
  logic        found, have_free, have_victim, coll;
  logic [IW-1:0] hit, free_i, vic_i, tgt;
  logic [31:0] vic_seen;

  // Grey threshold from the register; the grace is round(interval/4), at least 2.
  logic [16:0] grace;
  logic [17:0] limit;
  logic [31:0] thr_ms;

  always_comb begin
    grace = ({1'b0, interval} + 17'd2) >> 2;
    if (grace < 17'd2) grace = 17'd2;
    limit  = {2'd0, interval} + {1'b0, grace};
    thr_ms = ({14'd0, limit} + 32'd1) * 32'd1000;
  end

  function automatic logic [31:0] age_ms(input logic [31:0] ls, input logic [31:0] t);
    return (t >= ls) ? (t - ls) : 32'd0;
  endfunction

  // Grey when interval is nonzero and floor(age/1000) > limit: age >= (limit+1)*1000.
  function automatic logic is_grey(input logic [31:0] a, input logic [31:0] th,
                                   input logic [15:0] iv);
    return (iv != 16'd0) && (a >= th);
  endfunction

  logic [IW-1:0] cur;
  assign cur = idx;

  logic cur_grey;
  assign cur_grey = is_grey(age_ms(seen_q[cur], now), thr_ms, interval);

  // The short id is built two bytes per cycle, starting from the node id latched at take.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_cnt <= 2'd3;
    end else if (take) begin
      act     <= action;
      in_key  <= node_id;
      in_seq  <= seq;
      in_pv   <= fix_valid;
      in_lat  <= lat;
      in_lon  <= lon;
      in_rssi <= rssi;
      now     <= now_ms;
      sid_new <= crc_byte(crc_byte(CRC_INIT, node_id[7:0]), node_id[15:8]);
      crc_cnt <= 2'd1;
    end else if (crc_cnt != 2'd3) begin
      sid_new <= crc_byte(crc_byte(sid_new, in_key[16*crc_cnt +: 8]),
                          in_key[16*crc_cnt+8 +: 8]);
      crc_cnt <= crc_cnt + 2'd1;
    end
  end

  // Scan unit: visits one slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning  <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      scan_done <= 1'b0;
      if (cmd.scan_start) begin
        scanning <= 1'b1;
        mode     <= cmd.scan_mode;
        idx      <= '0;
        if (cmd.scan_mode == SCAN_FIND) begin
          found <= 1'b0;
          have_free <= 1'b0;
        end
        have_victim <= 1'b0;
        coll <= 1'b0;
      end else if (scanning) begin
        case (mode)
          SCAN_FIND: begin
            if (used[cur] && key_q[cur] == in_key && !found) begin
              found <= 1'b1;
              hit   <= cur;
            end
            if (!used[cur] && !have_free) begin
              have_free <= 1'b1;
              free_i    <= cur;
            end
          end
          SCAN_GREY, SCAN_ANY: begin
            if (used[cur] && !self_bit[cur] && (mode == SCAN_ANY || cur_grey) &&
                (!have_victim || seen_q[cur] < vic_seen)) begin
              have_victim <= 1'b1;
              vic_i       <= cur;
              vic_seen    <= seen_q[cur];
            end
          end
          SCAN_COLL: begin
            if (cur != tgt && used[cur] && sid_q[cur] == sid_q[tgt]) coll <= 1'b1;
          end
          default: ;
        endcase
        if (idx == IW'(TABLE_ENTRIES - 1)) begin
          scanning  <= 1'b0;
          scan_done <= 1'b1;
        end else begin
          idx <= idx + IW'(1);
        end
      end
    end
  end

  assign sts.scan_done = scan_done;
  assign sts.found = found;
  assign sts.have_free = have_free;
  assign sts.have_victim = have_victim;

  // Update of the chosen slot.
  logic [IW-1:0] ns;
  logic          newer;
  always_comb begin
    if (found) ns = hit;
    else if (have_free) ns = free_i;
    else ns = vic_i;
  end

  assign newer = seq_newer(in_seq, seq_q[ns]);

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      self_bit <= '0;
    end else if (cmd.apply) begin
      tgt <= ns;
      if (!found) begin
        used[ns]     <= 1'b1;
        self_bit[ns] <= (act == ACT_SELF);
        key_q[ns]    <= in_key;
        sid_q[ns]    <= (sid_new == 16'h0000 || sid_new == 16'hFFFF) ?
                        (sid_new ^ 16'h0001) : sid_new;
        seen_q[ns]   <= now;
        seq_q[ns]    <= 16'd0;
        rssi_q[ns]   <= 8'd0;
        pv_q[ns]     <= 1'b0;
        lat_q[ns]    <= '0;
        lon_q[ns]    <= '0;
        case (act)
          ACT_ALIVE: begin
            rssi_q[ns] <= in_rssi;
            seq_q[ns]  <= in_seq;
            if (in_pv) begin
              pv_q[ns]  <= 1'b1;
              lat_q[ns] <= in_lat;
              lon_q[ns] <= in_lon;
            end
          end
          ACT_FULL: begin
            rssi_q[ns] <= in_rssi;
            if (seq_newer(in_seq, 16'd0)) begin
              seq_q[ns] <= in_seq;
              pv_q[ns]  <= 1'b1;
              lat_q[ns] <= in_lat;
              lon_q[ns] <= in_lon;
            end
          end
          default: ;
        endcase
      end else begin
        case (act)
          ACT_ALIVE: begin
            if (!self_bit[ns]) begin
              if (newer) begin
                seq_q[ns] <= in_seq;
                if (in_pv) begin
                  pv_q[ns]  <= 1'b1;
                  lat_q[ns] <= in_lat;
                  lon_q[ns] <= in_lon;
                end
              end
              rssi_q[ns] <= in_rssi;
              seen_q[ns] <= now;
            end
          end
          ACT_FULL: begin
            if (newer) begin
              seq_q[ns] <= in_seq;
              pv_q[ns]  <= 1'b1;
              lat_q[ns] <= in_lat;
              lon_q[ns] <= in_lon;
            end
            rssi_q[ns] <= in_rssi;
            seen_q[ns] <= now;
          end
          ACT_SELF: begin
            pv_q[ns]     <= 1'b0;
            lat_q[ns]    <= '0;
            lon_q[ns]    <= '0;
            seen_q[ns]   <= now;
            self_bit[ns] <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Result word. Seconds come from a reciprocal multiply, exact for 32-bit ages.
  logic [31:0] a_ms_q;
  logic [63:0] a_prod;
  logic [25:0] a_s;

  always_ff @(posedge clk) begin
    a_ms_q <= age_ms(seen_q[tgt], now);
  end

  assign a_prod = {32'd0, a_ms_q} * 64'd274877907;
  assign a_s    = a_prod[63:38];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.result;
    end
    if (cmd.result) begin
      if (fail) begin
        ok <= 1'b0; slot <= '0; node_sid <= '0; collision <= 1'b0; grey <= 1'b0;
        is_self <= 1'b0; has_position <= 1'b0; out_lat <= '0; out_lon <= '0;
        stored_seq <= '0; stored_rssi <= '0; age_s <= '0;
      end else begin
        ok           <= 1'b1;
        slot         <= 5'(32'(tgt) & 32'h1F);
        node_sid     <= sid_q[tgt];
        collision    <= coll;
        grey         <= is_grey(a_ms_q, thr_ms, interval);
        is_self      <= self_bit[tgt];
        has_position <= pv_q[tgt];
        out_lat      <= pv_q[tgt] ? lat_q[tgt] : '0;
        out_lon      <= pv_q[tgt] ? lon_q[tgt] : '0;
        stored_seq   <= seq_q[tgt];
        stored_rssi  <= rssi_q[tgt];
        age_s        <= (a_s > 26'hFFFF) ? 16'hFFFF : a_s[15:0];
      end
    end
  end

endmodule

/* src/peer_node_table_update_top.sv */
// ----------------------------------------------------------------------------
// peer_node_table_update_top
// Peer table keyed by 48-bit node id with sequence, position and eviction.
//
// Channel   Signals                                Handshake
// input     action .. now_ms                       start high, busy low
// result    ok .. age_s                            done strobe, one cycle
// config    psel penable pwrite paddr pwdata       APB, pready tied high
//
// A found key or free slot runs the find, update and collision steps; a grey
// eviction adds the grey scan, init-self fallback the any-slot scan too, and a
// lookup miss runs the find scan alone, each scan on the single scan port. busy
// falls in the done cycle, so a new item waits for the last. Reset clears every
// slot's in-use bit at once. The receiver cannot stall.
// ----------------------------------------------------------------------------
module peer_node_table_update_top import pntu_pkg::*; #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [47:0] node_id,
  input  logic [15:0] seq,
  input  logic        fix_valid,
  input  logic signed [30:0] lat,
  input  logic signed [31:0] lon,
  input  logic [15:0] pos_age,
  input  logic [15:0] fix_quality,
  input  logic signed [7:0] rssi,
  input  logic [31:0] now_ms,
  output logic        done,
  output logic        ok,
  output logic [4:0]  slot,
  output logic [15:0] node_sid,
  output logic        collision,
  output logic        grey,
  output logic        is_self,
  output logic        has_position,
  output logic signed [30:0] out_lat,
  output logic signed [31:0] out_lon,
  output logic [15:0] stored_seq,
  output logic signed [7:0] stored_rssi,
  output logic [15:0] age_s
);

  logic [15:0] interval;
  pntu_cmd_t cmd;
  pntu_sts_t sts;
  logic fail;
  logic take;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_INTERVAL) ? {16'd0, interval} : 32'd0;
  assign take   = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= '0;
    end else if (psel && penable && pwrite && paddr == REG_INTERVAL) begin
      interval <= pwdata[15:0];
    end
  end

  pntu_ctrl u_ctrl (
    .clk, .rst, .start, .action, .sts, .cmd, .busy, .fail
  );

  pntu_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst, .take, .action, .node_id, .seq, .fix_valid, .lat, .lon,
    .rssi, .now_ms, .interval, .cmd, .fail, .sts, .done,
    .ok, .slot, .node_sid, .collision, .grey, .is_self, .has_position,
    .out_lat, .out_lon, .stored_seq, .stored_rssi, .age_s
  );

endmodule
